FILE: rtl/dssd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the decimal seven-segment serial driver.
// Used by the controller, the datapath and the top level.
package dssd_pkg;

  localparam int unsigned ValueW = 12;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned DigitW = 4;

  localparam logic [ByteW-1:0] BlankPattern = 8'hFF;

  // Reciprocal of ten scaled by 2^15; exact for every 12-bit value.
  localparam int unsigned RecipShift = 15;
  localparam logic [ValueW-1:0] RecipTen = 12'd3277;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture a new request
    logic step;   // convert one decimal digit
    logic shift;  // advance the serial frame by one bit
  } dssd_cmd_t;

  // Segment pattern of one decimal digit, before the active-low inversion.
  function automatic logic [ByteW-1:0] seg_lookup(input logic [DigitW-1:0] digit);
    logic [ByteW-1:0] pattern;
    case (digit)
      4'd0:    pattern = 8'hBE;
      4'd1:    pattern = 8'hA0;
      4'd2:    pattern = 8'h2F;
      4'd3:    pattern = 8'hAB;
      4'd4:    pattern = 8'hB1;
      4'd5:    pattern = 8'h9B;
      4'd6:    pattern = 8'h9F;
      4'd7:    pattern = 8'hA8;
      4'd8:    pattern = 8'hBF;
      4'd9:    pattern = 8'hBB;
      default: pattern = 8'h00;
    endcase
    return pattern;
  endfunction

endpackage

FILE: rtl/dssd_ctrl.sv
`timescale 1ns / 1ps
// Controller of the decimal seven-segment serial driver: sequences digit
// conversion and the serial shift-out. Depends on dssd_pkg.
module dssd_ctrl #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               latch_now_o,
  output dssd_pkg::dssd_cmd_t cmd_o
);
  import dssd_pkg::*;

  localparam int unsigned FrameBits = ByteW * DIGIT_COUNT;
  localparam int unsigned CntW      = $clog2(FrameBits);
  localparam logic [CntW-1:0] LastDigit = CntW'(DIGIT_COUNT - 1);
  localparam logic [CntW-1:0] LastBit   = CntW'(FrameBits - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SHIFT
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        cmd_o.step = 1'b1;
        if (cnt_q == LastDigit) begin
          cnt_d   = '0;
          state_d = ST_SHIFT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SHIFT: begin
        if (out_ready_i) begin
          cmd_o.shift = 1'b1;
          if (cnt_q == LastBit) begin
            cnt_d   = '0;
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_SHIFT);
  assign latch_now_o = out_valid_o && (cnt_q == LastBit);

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a frame is still being sent");

  a_accept_starts_convert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (!in_ready_o && !out_valid_o))
    else $error("accepted request did not enter digit conversion");

  a_latch_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (latch_now_o && out_ready_i) |=> in_ready_o)
    else $error("frame did not end after the latch bit");

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.step, cmd_o.shift}))
    else $error("more than one datapath command at once");
`endif

endmodule

FILE: rtl/dssd_datapath.sv
`timescale 1ns / 1ps
// Datapath of the decimal seven-segment serial driver: digit split by a
// reciprocal multiply, segment lookup and the serial frame register.
// Depends on dssd_pkg.
module dssd_datapath #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  logic                          clk_i,
  input  dssd_pkg::dssd_cmd_t           cmd_i,
  input  logic [dssd_pkg::ValueW-1:0]   sample_value_i,
  output logic                          serial_bit_o
);
  import dssd_pkg::*;

  localparam int unsigned FrameBits = ByteW * DIGIT_COUNT;
  localparam int unsigned ProdW     = 2 * ValueW;

  logic [ValueW-1:0]    rest_q, rest_d;
  logic [FrameBits-1:0] frame_q, frame_d;
  logic [ProdW-1:0]     prod;
  logic [ValueW-1:0]    quot;
  logic [ValueW-1:0]    quot_x10;
  logic [DigitW-1:0]    digit;
  logic [ByteW-1:0]     seg_byte;

  // floor(rest / 10) and the remainder.
  assign prod     = rest_q * ProdW'(RecipTen);
  assign quot     = ValueW'(prod >> RecipShift);
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign digit    = DigitW'(rest_q - quot_x10);
  assign seg_byte = (rest_q != '0) ? ~seg_lookup(digit) : BlankPattern;

  always_comb begin
    rest_d  = rest_q;
    frame_d = frame_q;
    if (cmd_i.load) begin
      rest_d = sample_value_i;
    end else if (cmd_i.step) begin
      // Enter the new digit at the top; earlier digits move toward the ones end.
      rest_d  = quot;
      frame_d = FrameBits'({seg_byte, frame_q} >> ByteW);
    end else if (cmd_i.shift) begin
      frame_d = frame_q << 1;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q  <= rest_d;
    frame_q <= frame_d;
  end

  assign serial_bit_o = frame_q[FrameBits-1];

endmodule

FILE: rtl/decimal_seven_segment_serial_driver.sv
`timescale 1ns / 1ps
// Decimal seven-segment serial driver. Each accepted 12-bit reading is split
// into DIGIT_COUNT decimal digits, one digit per cycle through a reciprocal
// multiply, mapped to active-low segment bytes (blank above the leading digit,
// all blank for zero), then sent as 8*DIGIT_COUNT serial bits, most significant
// position first and each byte MSB first, one bit per accepted output request.
// latch_now_o marks the final bit. A new reading is taken only after the last bit.
module decimal_seven_segment_serial_driver #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dssd_pkg::ValueW-1:0] sample_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        serial_bit_o,
  output logic                        latch_now_o
);
  import dssd_pkg::*;

  dssd_cmd_t cmd;

  dssd_ctrl #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .latch_now_o(latch_now_o),
    .cmd_o      (cmd)
  );

  dssd_datapath #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_datapath (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .sample_value_i(sample_value_i),
    .serial_bit_o  (serial_bit_o)
  );

endmodule
